FILE: design/sfc_pkg.sv
package sfc_pkg;

  localparam int MAX_CARS_DEFAULT = 63;

  localparam logic [7:0] HDR_BYTE = 8'h55;
  localparam logic [7:0] FIXED_BYTES_MINUS_ONE = 8'd7;
  localparam logic [7:0] POS_SATURATED = 8'd255;
  localparam logic [7:0] POS_FIRST_STATUS = 8'd7;

  localparam logic [7:0] POS_HDR1 = 8'd1;
  localparam logic [7:0] POS_CAR_LO = 8'd2;
  localparam logic [7:0] POS_CAR_HI = 8'd3;
  localparam logic [7:0] POS_COUNT = 8'd4;
  localparam logic [7:0] POS_SENS_LO = 8'd5;
  localparam logic [7:0] POS_SENS_HI = 8'd6;

  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  typedef struct packed {
    logic        start;
    logic        ok;
    logic [15:0] first_car;
    logic [7:0]  count;
    logic [15:0] sensor;
  } frame_info_t;

  typedef struct packed {
    logic        item_kind;
    logic [15:0] entry_index;
    logic [7:0]  status_value;
    logic        frame_ok;
    logic [15:0] first_car;
    logic [7:0]  car_count;
    logic [15:0] sensor_number;
    logic        last;
  } out_word_t;

endpackage

FILE: design/sfc_ifs.sv
interface sfc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       frame_end;

  modport source(output valid, output rx_byte, output frame_end, input ready);
  modport sink(input valid, input rx_byte, input frame_end, output ready);
endinterface

interface sfc_out_if;
  logic        valid;
  logic        ready;
  logic        item_kind;
  logic [15:0] entry_index;
  logic [7:0]  status_value;
  logic        frame_ok;
  logic [15:0] first_car;
  logic [7:0]  car_count;
  logic [15:0] sensor_number;
  logic        last;

  modport source(output valid, output item_kind, output entry_index, output status_value,
                 output frame_ok, output first_car, output car_count,
                 output sensor_number, output last, input ready);
  modport sink(input valid, input item_kind, input entry_index, input status_value,
               input frame_ok, input first_car, input car_count,
               input sensor_number, input last, output ready);
endinterface

FILE: design/sfc_ram.sv
module sfc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 63,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: design/sfc_parser.sv
module sfc_parser #(
  parameter int MAX_CARS_PER_FRAME = sfc_pkg::MAX_CARS_DEFAULT,
  localparam int AW = (MAX_CARS_PER_FRAME > 1) ? $clog2(MAX_CARS_PER_FRAME) : 1
) (
  input  logic                  clk,
  input  logic                  rst_n,
  sfc_in_if.sink                in_ch,
  input  logic                  busy,
  output logic                  mem_we,
  output logic [AW-1:0]         mem_waddr,
  output logic [7:0]            mem_wdata,
  output sfc_pkg::frame_info_t  info
);

  logic [7:0]  pos_r, pos_nxt;
  logic [7:0]  sum_r, sum_nxt;
  logic        hdr_ok_r, hdr_ok_nxt;
  logic [15:0] car_r, car_nxt;
  logic [7:0]  cnt_r, cnt_nxt;
  logic [15:0] sens_r, sens_nxt;
  logic        take;
  logic [7:0]  slot;
  logic [7:0]  b;
  logic        ok;

  assign in_ch.ready = !busy;
  assign take = in_ch.valid && !busy;
  assign b = in_ch.rx_byte;
  assign slot = pos_r - sfc_pkg::POS_FIRST_STATUS;

  assign mem_we = take && !in_ch.frame_end && (pos_r >= sfc_pkg::POS_FIRST_STATUS) &&
                  (pos_r != sfc_pkg::POS_SATURATED) && (slot < 8'(MAX_CARS_PER_FRAME));
  assign mem_waddr = slot[AW-1:0];
  assign mem_wdata = b;

  // The frame length is pos_r + 1, which must equal count + 8.
  assign ok = hdr_ok_r && (pos_r != sfc_pkg::POS_SATURATED) &&
              (pos_r >= sfc_pkg::POS_SENS_HI) &&
              ({1'b0, pos_r} == ({1'b0, cnt_r} + {1'b0, sfc_pkg::FIXED_BYTES_MINUS_ONE})) &&
              (cnt_r <= 8'(MAX_CARS_PER_FRAME)) && (b == sum_r);

  always_comb begin
    info.start = take && in_ch.frame_end;
    info.ok = ok;
    info.first_car = car_r;
    info.count = cnt_r;
    info.sensor = sens_r;
  end

  always_comb begin
    pos_nxt = pos_r;
    sum_nxt = sum_r;
    hdr_ok_nxt = hdr_ok_r;
    car_nxt = car_r;
    cnt_nxt = cnt_r;
    sens_nxt = sens_r;
    if (take) begin
      if (in_ch.frame_end) begin
        pos_nxt = '0;
        sum_nxt = '0;
        hdr_ok_nxt = 1'b1;
      end else begin
        if (pos_r <= sfc_pkg::POS_HDR1 && b != sfc_pkg::HDR_BYTE) begin
          hdr_ok_nxt = 1'b0;
        end
        case (pos_r)
          sfc_pkg::POS_CAR_LO:  car_nxt = {car_r[15:8], b};
          sfc_pkg::POS_CAR_HI:  car_nxt = {b, car_r[7:0]};
          sfc_pkg::POS_COUNT:   cnt_nxt = b;
          sfc_pkg::POS_SENS_LO: sens_nxt = {sens_r[15:8], b};
          sfc_pkg::POS_SENS_HI: sens_nxt = {b, sens_r[7:0]};
          default: ;
        endcase
        sum_nxt = sum_r + b;
        if (pos_r != sfc_pkg::POS_SATURATED) begin
          pos_nxt = pos_r + 8'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      sum_r <= '0;
      hdr_ok_r <= 1'b1;
      car_r <= '0;
      cnt_r <= '0;
      sens_r <= '0;
    end else begin
      pos_r <= pos_nxt;
      sum_r <= sum_nxt;
      hdr_ok_r <= hdr_ok_nxt;
      car_r <= car_nxt;
      cnt_r <= cnt_nxt;
      sens_r <= sens_nxt;
    end
  end

endmodule

FILE: design/sfc_drain.sv
module sfc_drain #(
  parameter int MAX_CARS_PER_FRAME = sfc_pkg::MAX_CARS_DEFAULT,
  localparam int AW = (MAX_CARS_PER_FRAME > 1) ? $clog2(MAX_CARS_PER_FRAME) : 1
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  sfc_pkg::frame_info_t  info,
  output logic                  busy,
  output logic                  mem_re,
  output logic [AW-1:0]         mem_raddr,
  input  logic [7:0]            mem_rdata,
  sfc_out_if.source             out_ch
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DRAIN = 2'd1;
  localparam logic [1:0] ST_SUM = 2'd2;

  logic [1:0]         state_r, state_nxt;
  logic               ok_r, ok_nxt;
  logic [15:0]        car_r, car_nxt;
  logic [7:0]         cnt_r, cnt_nxt;
  logic [15:0]        sens_r, sens_nxt;
  logic [7:0]         rd_idx_r, rd_idx_nxt;
  logic [7:0]         pend_idx_r, pend_idx_nxt;
  logic               pend_r, pend_nxt;
  logic               out_valid_r, out_valid_nxt;
  sfc_pkg::out_word_t out_r, out_nxt;
  logic               out_free;
  logic               load;
  logic               issue;

  assign busy = (state_r != ST_IDLE);
  assign out_free = !out_valid_r || out_ch.ready;
  assign load = (state_r == ST_DRAIN) && pend_r && out_free;
  assign issue = (state_r == ST_DRAIN) && (rd_idx_r < cnt_r) && (!pend_r || load);
  assign mem_re = issue;
  assign mem_raddr = rd_idx_r[AW-1:0];

  always_comb begin
    state_nxt = state_r;
    ok_nxt = ok_r;
    car_nxt = car_r;
    cnt_nxt = cnt_r;
    sens_nxt = sens_r;
    rd_idx_nxt = rd_idx_r;
    pend_idx_nxt = pend_idx_r;
    pend_nxt = pend_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_nxt = out_r;
    case (state_r)
      ST_IDLE: begin
        if (info.start) begin
          ok_nxt = info.ok;
          car_nxt = info.first_car;
          cnt_nxt = info.count;
          sens_nxt = info.sensor;
          rd_idx_nxt = '0;
          pend_nxt = 1'b0;
          state_nxt = (info.ok && info.count != 8'd0) ? ST_DRAIN : ST_SUM;
        end
      end
      ST_DRAIN: begin
        if (load) begin
          out_valid_nxt = 1'b1;
          out_nxt = '0;
          out_nxt.item_kind = sfc_pkg::KIND_WRITE;
          out_nxt.entry_index = car_r + {8'd0, pend_idx_r} - 16'd1;
          out_nxt.status_value = mem_rdata;
        end
        if (issue) begin
          pend_idx_nxt = rd_idx_r;
          rd_idx_nxt = rd_idx_r + 8'd1;
          pend_nxt = 1'b1;
        end else if (load) begin
          pend_nxt = 1'b0;
          state_nxt = ST_SUM;
        end
      end
      ST_SUM: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_nxt = '0;
          out_nxt.item_kind = sfc_pkg::KIND_SUMMARY;
          out_nxt.frame_ok = ok_r;
          out_nxt.last = 1'b1;
          if (ok_r) begin
            out_nxt.first_car = car_r;
            out_nxt.car_count = cnt_r;
            out_nxt.sensor_number = sens_r;
          end
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      pend_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pend_r <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ok_r <= ok_nxt;
    car_r <= car_nxt;
    cnt_r <= cnt_nxt;
    sens_r <= sens_nxt;
    rd_idx_r <= rd_idx_nxt;
    pend_idx_r <= pend_idx_nxt;
    out_r <= out_nxt;
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.item_kind = out_r.item_kind;
  assign out_ch.entry_index = out_r.entry_index;
  assign out_ch.status_value = out_r.status_value;
  assign out_ch.frame_ok = out_r.frame_ok;
  assign out_ch.first_car = out_r.first_car;
  assign out_ch.car_count = out_r.car_count;
  assign out_ch.sensor_number = out_r.sensor_number;
  assign out_ch.last = out_r.last;

endmodule

FILE: design/status_frame_checker.sv
// Checks received status frames and turns accepted ones into status table writes.
// The input channel takes one received byte per word, with frame_end set on the
// checksum byte that closes the frame. Header, count and sensor fields are held in
// registers and the status bytes go into a small buffer memory.
// Bytes before the final one are taken at one word per cycle. After the final byte
// the block stops taking input while it reads the buffer back through the memory's
// single read port, one entry per cycle while the receiver keeps up: an accepted
// frame gives one write word per status byte, each read from the buffer and then
// held in the output register, then the summary word with last set. A rejected
// frame or one with no status bytes gives only its summary word.
// The result channel has an output register, so a waiting result does not stop the
// block from taking the bytes of the next frame. When the receiver stalls, the read
// back pauses and no word is lost or repeated.
// Reset clears the byte position and checksum, sets the header flag and returns to
// taking bytes at once; the buffer needs no clearing because a frame reads back only
// the entries that it wrote.
module status_frame_checker #(
  parameter int MAX_CARS_PER_FRAME = sfc_pkg::MAX_CARS_DEFAULT,
  localparam int AW = (MAX_CARS_PER_FRAME > 1) ? $clog2(MAX_CARS_PER_FRAME) : 1
) (
  input  logic       clk,
  input  logic       rst_n,
  sfc_in_if.sink     in_ch,
  sfc_out_if.source  out_ch
);

  sfc_pkg::frame_info_t info;
  logic                 busy;
  logic                 mem_we;
  logic [AW-1:0]        mem_waddr;
  logic [7:0]           mem_wdata;
  logic                 mem_re;
  logic [AW-1:0]        mem_raddr;
  logic [7:0]           mem_rdata;

  sfc_parser #(.MAX_CARS_PER_FRAME(MAX_CARS_PER_FRAME)) u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .busy      (busy),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .info      (info)
  );

  sfc_ram #(.WIDTH(8), .DEPTH(MAX_CARS_PER_FRAME)) u_buf (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  sfc_drain #(.MAX_CARS_PER_FRAME(MAX_CARS_PER_FRAME)) u_drain (
    .clk       (clk),
    .rst_n     (rst_n),
    .info      (info),
    .busy      (busy),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata),
    .out_ch    (out_ch)
  );

endmodule
